/* rtl/core/cnfsa_pkg.sv */
// Package for the circular next-free slot allocator.
// Holds sizes, status codes, controller states and the command struct.
// Depends on nothing; every other file imports it.
`default_nettype none

package cnfsa_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CNT_W-1:0] SLOTS_IN_USE_RESET = CNT_W'(SLOTS);

    localparam logic [0:0] REG_SLOTS_IN_USE = 1'b0;

    localparam logic [1:0] STATUS_GRANTED = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_FIND
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/cnfsa_regs.sv */
// Configuration register block with an APB-style slave port.
// Holds the slot count register; depends on cnfsa_pkg.
`default_nettype none

module cnfsa_regs
    import cnfsa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [CNT_W-1:0]   slots_in_use
);

    logic [CNT_W-1:0] slots_in_use_reg;
    logic [CNT_W-1:0] slots_in_use_next;
    logic             reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_SLOTS_IN_USE);

    always_comb
    begin
        slots_in_use_next = slots_in_use_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            slots_in_use_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= SLOTS_IN_USE_RESET;
        end
        else
        begin
            slots_in_use_reg <= slots_in_use_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_hit)
        begin
            prdata = PDATA_W'(slots_in_use_reg);
        end
    end

    assign slots_in_use = slots_in_use_reg;

endmodule

`default_nettype wire

/* rtl/core/cnfsa_ctrl.sv */
// Controller state machine: input handshake, search sequencing, output valid.
// Drives datapath commands; depends on cnfsa_pkg.
`default_nettype none

module cnfsa_ctrl
    import cnfsa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output dp_cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_FIND:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/core/cnfsa_dp.sv */
// Datapath: occupancy map, wrapped first-free search and result registers.
// Acts on controller commands; depends on cnfsa_pkg.
`default_nettype none

module cnfsa_dp
    import cnfsa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    input  wire logic [CNT_W-1:0]  slots_in_use,
    input  wire logic [SLOT_W-1:0] preferred_slot,
    output logic      [SLOT_W-1:0] granted_slot,
    output logic      [1:0]        status
);

    logic [SLOT_W-1:0] pref_reg;
    logic [SLOTS-1:0]  map_reg;
    logic [SLOTS-1:0]  map_next;
    logic [SLOT_W-1:0] grant_reg;
    logic [SLOT_W-1:0] grant_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;

    logic [CNT_W-1:0]  active_cnt;
    logic [SLOTS-1:0]  active_mask;
    logic [SLOTS-1:0]  upper_mask;
    logic [SLOTS-1:0]  free_vec;
    logic [SLOTS-1:0]  upper_free;
    logic [SLOT_W-1:0] found_slot;
    logic              out_of_range;

    function automatic logic [SLOT_W-1:0] first_set(input logic [SLOTS-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    assign active_cnt = (slots_in_use > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : slots_in_use;
    assign out_of_range = ({1'b0, pref_reg} >= active_cnt);

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            active_mask[i] = (CNT_W'(i) < active_cnt);
            upper_mask[i]  = (SLOT_W'(i) >= pref_reg);
        end
    end

    assign free_vec   = ~map_reg & active_mask;
    assign upper_free = free_vec & upper_mask;
    assign found_slot = (|upper_free) ? first_set(upper_free) : first_set(free_vec);

    always_comb
    begin
        map_next    = map_reg;
        grant_next  = grant_reg;
        status_next = status_reg;
        if (cmd.commit)
        begin
            if (out_of_range)
            begin
                grant_next  = '0;
                status_next = STATUS_RANGE;
            end
            else if (!(|free_vec))
            begin
                grant_next  = '0;
                status_next = STATUS_FULL;
            end
            else
            begin
                grant_next           = found_slot;
                status_next          = STATUS_GRANTED;
                map_next[found_slot] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
        end
        else
        begin
            map_reg <= map_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pref_reg <= preferred_slot;
        end
        grant_reg  <= grant_next;
        status_reg <= status_next;
    end

    assign granted_slot = grant_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

/* rtl/core/circular_next_free_slot_allocator.sv */
// Circular next-free slot allocator, top level.
// A request is accepted in ST_IDLE, which captures the preferred slot. In ST_FIND the search
// and map update commit once the output register is free; only then is a new request taken.
// A finished result waits in the output register while the next request is accepted.
// Reset (rst_n, asynchronous): all slots free, slot count 64, no result pending.
// Depends on cnfsa_pkg, cnfsa_regs, cnfsa_ctrl and cnfsa_dp.
`default_nettype none

module circular_next_free_slot_allocator
    import cnfsa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [5:0]         preferred_slot,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [5:0]         granted_slot,
    output logic      [1:0]         status
);

    logic [CNT_W-1:0] slots_in_use;
    dp_cmd_t          cmd;

    cnfsa_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .slots_in_use (slots_in_use)
    );

    cnfsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    cnfsa_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .slots_in_use   (slots_in_use),
        .preferred_slot (preferred_slot),
        .granted_slot   (granted_slot),
        .status         (status)
    );

endmodule

`default_nettype wire
